// File: sv/rossler_pkg.sv
// Package for the Rossler RK2 step core: word format, register indexes,
// and the saturating fixed-point helpers used by the datapath.
// Depends on nothing.
`default_nettype none

package rossler_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 24;
  localparam int DT_BITS   = 24;
  localparam int CFG_IDX_BITS = 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [WORD_BITS:0]   opnd_t;
  typedef logic [DT_BITS-1:0]          dt_t;

  typedef struct packed {
    logic  hit;
    word_t val;
  } sat_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COEF_A    = 3'd0,
    REG_COEF_B    = 3'd1,
    REG_COEF_C    = 3'd2,
    REG_TIME_STEP = 3'd3,
    REG_START_X   = 3'd4,
    REG_START_Y   = 3'd5,
    REG_START_Z   = 3'd6,
    REG_NONE      = 3'd7
  } cfg_idx_t;

  localparam word_t WMAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WMIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  localparam word_t COEF_A_RST    = word_t'(1677722);
  localparam word_t COEF_B_RST    = word_t'(1677722);
  localparam word_t COEF_C_RST    = word_t'(16777216);
  localparam dt_t   TIME_STEP_RST = dt_t'(167772);

  function automatic sat_t add_s(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    sat_t r;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    r.hit = s[WORD_BITS] != s[WORD_BITS-1];
    r.val = r.hit ? (s[WORD_BITS] ? WMIN : WMAX) : word_t'(s[WORD_BITS-1:0]);
    return r;
  endfunction

  function automatic sat_t sub_s(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    sat_t r;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    r.hit = s[WORD_BITS] != s[WORD_BITS-1];
    r.val = r.hit ? (s[WORD_BITS] ? WMIN : WMAX) : word_t'(s[WORD_BITS-1:0]);
    return r;
  endfunction

  function automatic word_t neg_s(input word_t a);
    return (a == WMIN) ? WMAX : word_t'(-a);
  endfunction

  // floor halving
  function automatic word_t half(input word_t a);
    return word_t'(a >>> 1);
  endfunction

  function automatic opnd_t widen(input word_t a);
    return opnd_t'($signed({a[WORD_BITS-1], a}));
  endfunction

  // full product, floor shift by FRAC_BITS, clip to word range
  function automatic word_t mul_q(input opnd_t a, input opnd_t b);
    logic signed [2*WORD_BITS+1:0]           p;
    logic signed [2*WORD_BITS+1-FRAC_BITS:0] q;
    word_t r;
    p = a * b;
    q = $signed(p[2*WORD_BITS+1:FRAC_BITS]);
    if (q > WMAX) r = WMAX;
    else if (q < WMIN) r = WMIN;
    else r = word_t'(q[WORD_BITS-1:0]);
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/rossler_rk2_step_core.sv
// Rossler RK2 step core: one second-order integration step per integration
// beat on a single shared multiplier. Depends on rossler_pkg.
`default_nettype none

// Each input beat either reloads the configured start point (reload = 1) or
// advances the state (x, y, z) by one RK2 step of size time_step; each beat
// yields exactly one result beat with the new state. A reload beat registers
// its result in ST_LD, then returns to ST_IDLE. An integration beat runs two
// slope evaluations, each through ST_AY, ST_XZ, ST_CZ, ST_KX, ST_KY, ST_KZ and
// ST_FIN, on one 33x33 signed multiplier and registers its result in the
// second ST_FIN; the next beat is accepted in the cycle after that, so no new
// beat is taken before the last is through. A previous result still waiting on
// out_ready holds the sequencer as long as it waits. All products round toward
// minus infinity and every sum saturates to Q8.24; saturated flags clipping of
// the new state. The user must write configuration only while no beat is in
// flight; the core itself does not enforce this.
module rossler_rk2_step_core (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire                              in_reload,
  output logic                             out_valid,
  input  wire                              out_ready,
  output rossler_pkg::word_t               out_pos_x,
  output rossler_pkg::word_t               out_pos_y,
  output rossler_pkg::word_t               out_pos_z,
  output logic                             out_saturated,
  input  wire                              cfg_we,
  input  wire [rossler_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire [rossler_pkg::WORD_BITS-1:0] cfg_wdata
);
  import rossler_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_LD   = 9'b000000010,
    ST_AY   = 9'b000000100,
    ST_XZ   = 9'b000001000,
    ST_CZ   = 9'b000010000,
    ST_KX   = 9'b000100000,
    ST_KY   = 9'b001000000,
    ST_KZ   = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_t;

  state_t st_r, st_nxt;
  logic   ph_r;

  word_t coef_a_r, coef_b_r, coef_c_r;
  dt_t   dt_r;
  word_t start_x_r, start_y_r, start_z_r;

  word_t cur_x_r, cur_y_r, cur_z_r;
  word_t hx_r, hy_r, hz_r;
  word_t k1x_r, k1y_r, k1z_r;
  word_t ty_r, tz_r;
  word_t p_r;
  logic  sat_acc_r;

  logic  out_valid_r, out_sat_r;
  word_t out_x_r, out_y_r, out_z_r;

  logic  in_fire, out_free, out_load;
  word_t xs, ys, zs;
  opnd_t mul_a, mul_b;
  word_t mul_y;
  word_t cmp_cur, cmp_k1;
  sat_t  h_sum, k_sum, new_sum, s1_sum, ty_sum, tzb_sum, tzc_sum;

  assign in_ready      = st_r == ST_IDLE;
  assign in_fire       = in_valid && in_ready;
  assign out_free      = !out_valid_r || out_ready;
  assign out_load      = out_free && (st_r == ST_LD || (st_r == ST_FIN && ph_r));
  assign out_valid     = out_valid_r;
  assign out_pos_x     = out_x_r;
  assign out_pos_y     = out_y_r;
  assign out_pos_z     = out_z_r;
  assign out_saturated = out_sat_r;

  assign xs = ph_r ? hx_r : cur_x_r;
  assign ys = ph_r ? hy_r : cur_y_r;
  assign zs = ph_r ? hz_r : cur_z_r;

  assign s1_sum  = sub_s(neg_s(ys), zs);
  assign ty_sum  = add_s(xs, p_r);
  assign tzb_sum = add_s(coef_b_r, p_r);
  assign tzc_sum = sub_s(tz_r, p_r);

  always_comb begin
    mul_a = widen(coef_a_r);
    mul_b = widen(ys);
    cmp_cur = cur_z_r;
    cmp_k1  = k1z_r;
    unique case (st_r)
      ST_XZ: begin
        mul_a = widen(xs);
        mul_b = widen(zs);
      end
      ST_CZ: begin
        mul_a = widen(coef_c_r);
        mul_b = widen(zs);
      end
      ST_KX: begin
        mul_a = widen(s1_sum.val);
        mul_b = opnd_t'($signed({{(WORD_BITS+1-DT_BITS){1'b0}}, dt_r}));
      end
      ST_KY: begin
        mul_a = widen(ty_r);
        mul_b = opnd_t'($signed({{(WORD_BITS+1-DT_BITS){1'b0}}, dt_r}));
        cmp_cur = cur_x_r;
        cmp_k1  = k1x_r;
      end
      ST_KZ: begin
        mul_a = widen(tz_r);
        mul_b = opnd_t'($signed({{(WORD_BITS+1-DT_BITS){1'b0}}, dt_r}));
        cmp_cur = cur_y_r;
        cmp_k1  = k1y_r;
      end
      default: begin
      end
    endcase
  end

  assign mul_y   = mul_q(mul_a, mul_b);
  assign h_sum   = add_s(cmp_cur, half(p_r));
  assign k_sum   = add_s(cmp_k1, p_r);
  assign new_sum = add_s(cmp_cur, half(k_sum.val));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_IDLE: if (in_fire) begin
        st_nxt = in_reload ? ST_LD : ST_AY;
      end
      ST_LD:   if (out_free) begin
        st_nxt = ST_IDLE;
      end
      ST_AY:   st_nxt = ST_XZ;
      ST_XZ:   st_nxt = ST_CZ;
      ST_CZ:   st_nxt = ST_KX;
      ST_KX:   st_nxt = ST_KY;
      ST_KY:   st_nxt = ST_KZ;
      ST_KZ:   st_nxt = ST_FIN;
      ST_FIN:  begin
        if (!ph_r) st_nxt = ST_AY;
        else if (out_free) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      ph_r        <= 1'b0;
      out_valid_r <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      cur_z_r     <= '0;
      coef_a_r    <= COEF_A_RST;
      coef_b_r    <= COEF_B_RST;
      coef_c_r    <= COEF_C_RST;
      dt_r        <= TIME_STEP_RST;
      start_x_r   <= '0;
      start_y_r   <= '0;
      start_z_r   <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          REG_COEF_A:    coef_a_r  <= word_t'(cfg_wdata);
          REG_COEF_B:    coef_b_r  <= word_t'(cfg_wdata);
          REG_COEF_C:    coef_c_r  <= word_t'(cfg_wdata);
          REG_TIME_STEP: dt_r      <= cfg_wdata[DT_BITS-1:0];
          REG_START_X:   start_x_r <= word_t'(cfg_wdata);
          REG_START_Y:   start_y_r <= word_t'(cfg_wdata);
          REG_START_Z:   start_z_r <= word_t'(cfg_wdata);
          default: begin
          end
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (in_fire) begin
          ph_r      <= 1'b0;
          sat_acc_r <= 1'b0;
        end
        ST_LD: if (out_free) begin
          cur_x_r     <= start_x_r;
          cur_y_r     <= start_y_r;
          cur_z_r     <= start_z_r;
          out_x_r     <= start_x_r;
          out_y_r     <= start_y_r;
          out_z_r     <= start_z_r;
          out_sat_r   <= 1'b0;
        end
        ST_AY: p_r <= mul_y;
        ST_XZ: begin
          ty_r <= ty_sum.val;
          p_r  <= mul_y;
        end
        ST_CZ: begin
          tz_r <= tzb_sum.val;
          p_r  <= mul_y;
        end
        ST_KX: begin
          tz_r <= tzc_sum.val;
          p_r  <= mul_y;
        end
        ST_KY: begin
          p_r <= mul_y;
          if (!ph_r) begin
            k1x_r <= p_r;
            hx_r  <= h_sum.val;
          end else begin
            cur_x_r   <= new_sum.val;
            sat_acc_r <= sat_acc_r | new_sum.hit;
          end
        end
        ST_KZ: begin
          p_r <= mul_y;
          if (!ph_r) begin
            k1y_r <= p_r;
            hy_r  <= h_sum.val;
          end else begin
            cur_y_r   <= new_sum.val;
            sat_acc_r <= sat_acc_r | new_sum.hit;
          end
        end
        ST_FIN: begin
          if (!ph_r) begin
            k1z_r <= p_r;
            hz_r  <= h_sum.val;
            ph_r  <= 1'b1;
          end else if (out_free) begin
            cur_z_r     <= new_sum.val;
            out_x_r     <= cur_x_r;
            out_y_r     <= cur_y_r;
            out_z_r     <= new_sum.val;
            out_sat_r   <= sat_acc_r | new_sum.hit;
            ph_r        <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a beat while still working on the previous one");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r == ST_LD || (st_r == ST_FIN && ph_r)))
    else $error("result raised outside reload or final step");

  a_phase_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r |-> !(st_r == ST_IDLE || st_r == ST_LD))
    else $error("second slope phase left set while idle");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_FIN && ph_r && out_valid && !out_ready) |=> st_r == ST_FIN)
    else $error("final step left while result still pending");
`endif

endmodule

`default_nettype wire
